>>> src/hrrn_pkg.sv
// Shared types and codes for the ready-queue scheduler.
// No dependencies; the core, the checker and the testbench import this package.
package hrrn_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8   = CFG_IDX_W'(1);

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_HRRN = 1'b1;

  localparam logic [1:0] ST_ENQUEUED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  localparam logic [8:0] ALPHA_ONE   = 9'd256;
  localparam logic [8:0] ALPHA_RESET = 9'd128;

  typedef struct packed {
    logic        op;
    logic [31:0] now_time;
    logic [15:0] proc_id;
    logic [31:0] prior_estimate;
    logic [31:0] last_burst;
    logic        refresh_estimate;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_proc_id;
    logic [31:0] out_estimate;
    logic [31:0] wait_ticks;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_beat_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] arrival;
    logic [31:0] estimate;
    logic [31:0] order;
  } entry_t;

endpackage

>>> src/hrrn_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type comes from hrrn_pkg at instantiation.
interface hrrn_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/hrrn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module hrrn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data while no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/hrrn_mul2.sv
// Pair of registered 32x32 multipliers shared by the estimate update
// and the response-ratio cross-multiply. Depends on nothing.
module hrrn_mul2 (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a0,
  input  logic [31:0] b0,
  input  logic [31:0] a1,
  input  logic [31:0] b1,
  output logic [63:0] p0_r,
  output logic [63:0] p1_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= 64'(a0) * 64'(b0);
      p1_r <= 64'(a1) * 64'(b1);
    end
  end

endmodule

>>> src/hrrn_ready_queue_scheduler_core.sv
// Highest-response-ratio-next ready-queue scheduler, top level.
// Depends on hrrn_pkg, hrrn_chan_if, hrrn_ram and hrrn_mul2.
//
// Channels: in_ch takes one request beat (enqueue or dispatch), out_ch
// returns exactly one result beat per request; cfg_ch, always ready,
// writes sched_mode (index 0), alpha_q8 (index 1); other indexes ignored.
// The user must write it only while the block is idle; not enforced.
// The table lives in one slot memory kept packed: entries 0..count-1 are
// live, a dispatch moves the last entry into the freed slot.
// Sequence: an enqueue multiplies, then sums and stores, then loads out_ch.
// A dispatch on an empty table goes straight to the output load. A dispatch
// over live entries primes the read (read, then load the first candidate),
// cross-multiplies and compares each entry, then reads the last entry,
// moves it and loads out_ch.
// One request is in work at a time; in_ch is ready whenever the sequencer
// is idle, even while a finished result still waits in the output register.
// When out_ch stalls, a newly finished result holds in the sequencer until
// the output register frees.
// Reset empties the table and clears the order counter at once; no
// clearing pass is needed.
module hrrn_ready_queue_scheduler_core
  import hrrn_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  hrrn_chan_if.sink   in_ch,
  hrrn_chan_if.source out_ch,
  hrrn_chan_if.sink   cfg_ch
);

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ENQ_MUL  = 10'b00_0000_0010,
    S_ENQ_SUM  = 10'b00_0000_0100,
    S_DSP_RD0  = 10'b00_0000_1000,
    S_DSP_LD0  = 10'b00_0001_0000,
    S_SCAN_MUL = 10'b00_0010_0000,
    S_SCAN_CMP = 10'b00_0100_0000,
    S_LAST_RD  = 10'b00_1000_0000,
    S_LAST_WR  = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic             mode_r;
  logic [8:0]       alpha_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      order_cnt_r;
  in_beat_t         req_r;
  out_beat_t        res_r;
  out_beat_t        out_r;
  logic             out_valid_r;

  // Scan candidate and running best.
  logic [31:0]      cand_w_r, cand_age_r, cand_est_r;
  logic [15:0]      cand_pid_r;
  logic [IDX_W-1:0] cand_idx_r;
  logic [31:0]      best_w_r, best_age_r, best_est_r;
  logic [15:0]      best_pid_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             best_valid_r;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t           rd_entry, wr_entry;

  logic        mul_en;
  logic [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
  logic [63:0] prod0, prod1;

  logic [8:0]       alpha_sat, alpha_rest;
  logic [63:0]      est_sum;
  logic [31:0]      est_raw, est_new;
  logic             table_full;
  logic [IDX_W-1:0] last_idx;
  logic             cand_wins, cand_last;
  logic             in_fire, cfg_fire, emit_load;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign emit_load    = (state_r == S_EMIT) & (~out_valid_r | out_ch.ready);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // Burst estimate: (alpha*old + (256-alpha)*last) >> 8 on refresh, else old; floored at one.
  assign alpha_sat  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_rest = ALPHA_ONE - alpha_sat;
  assign est_sum    = prod0 + prod1;
  assign est_raw    = req_r.refresh_estimate ? est_sum[39:8] : req_r.prior_estimate;
  assign est_new    = (est_raw == 32'd0) ? 32'd1 : est_raw;

  assign table_full = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign cand_last  = (cand_idx_r == last_idx);

  // Ratio compare by cross-multiply; equal ratios and FIFO fall back to age.
  always_comb begin
    if (!best_valid_r) begin
      cand_wins = 1'b1;
    end else if (mode_r == MODE_HRRN && prod0 != prod1) begin
      cand_wins = (prod0 > prod1);
    end else begin
      cand_wins = (cand_age_r > best_age_r);
    end
  end

  // Multiplier operand select.
  always_comb begin
    mul_en = 1'b0;
    mul_a0 = cand_w_r;
    mul_b0 = best_est_r;
    mul_a1 = best_w_r;
    mul_b1 = cand_est_r;
    if (state_r == S_ENQ_MUL) begin
      mul_en = 1'b1;
      mul_a0 = 32'(alpha_sat);
      mul_b0 = req_r.prior_estimate;
      mul_a1 = 32'(alpha_rest);
      mul_b1 = req_r.last_burst;
    end else if (state_r == S_SCAN_MUL) begin
      mul_en = 1'b1;
    end
  end

  hrrn_mul2 u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a0   (mul_a0),
    .b0   (mul_b0),
    .a1   (mul_a1),
    .b1   (mul_b1),
    .p0_r (prod0),
    .p1_r (prod1)
  );

  // Slot memory ports.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cand_idx_r + IDX_W'(2);
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = ram_rdata;
    wr_entry.pid      = req_r.proc_id;
    wr_entry.arrival  = req_r.now_time;
    wr_entry.estimate = est_new;
    wr_entry.order    = order_cnt_r;
    unique case (state_r)
      S_ENQ_SUM: begin
        ram_we    = ~table_full;
        ram_waddr = IDX_W'(count_r);
        ram_wdata = wr_entry;
      end
      S_DSP_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_DSP_LD0: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(1);
      end
      S_SCAN_CMP: begin
        ram_re = 1'b1;
      end
      S_LAST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx;
      end
      S_LAST_WR: begin
        // Move the last entry into the slot being freed.
        ram_we = 1'b1;
      end
      S_IDLE, S_ENQ_MUL, S_SCAN_MUL, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign rd_entry = ram_rdata;

  hrrn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.payload.op == OP_ENQUEUE) begin
            state_nxt = S_ENQ_MUL;
          end else if (count_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DSP_RD0;
          end
        end
      end
      S_ENQ_MUL:  state_nxt = S_ENQ_SUM;
      S_ENQ_SUM:  state_nxt = S_EMIT;
      S_DSP_RD0:  state_nxt = S_DSP_LD0;
      S_DSP_LD0:  state_nxt = S_SCAN_MUL;
      S_SCAN_MUL: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = cand_last ? S_LAST_RD : S_SCAN_MUL;
      S_LAST_RD:  state_nxt = S_LAST_WR;
      S_LAST_WR:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_FIFO;
      alpha_r      <= ALPHA_RESET;
      count_r      <= '0;
      order_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
      best_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        if (cfg_ch.payload.reg_idx == REG_SCHED_MODE) begin
          mode_r <= cfg_ch.payload.wdata[0];
        end else if (cfg_ch.payload.reg_idx == REG_ALPHA_Q8) begin
          alpha_r <= cfg_ch.payload.wdata;
        end
      end
      if (state_r == S_ENQ_SUM && !table_full) begin
        count_r     <= count_r + CNT_W'(1);
        order_cnt_r <= order_cnt_r + 32'd1;
      end
      if (state_r == S_LAST_WR) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (state_r == S_DSP_LD0) begin
        best_valid_r <= 1'b0;
      end else if (state_r == S_SCAN_CMP) begin
        best_valid_r <= 1'b1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_ch.payload;
      res_r.status       <= ST_EMPTY;
      res_r.out_proc_id  <= '0;
      res_r.out_estimate <= '0;
      res_r.wait_ticks   <= '0;
    end
    if (state_r == S_ENQ_SUM) begin
      res_r.status       <= table_full ? ST_FULL : ST_ENQUEUED;
      res_r.out_proc_id  <= req_r.proc_id;
      res_r.out_estimate <= est_new;
      res_r.wait_ticks   <= '0;
    end
    if (state_r == S_LAST_WR) begin
      res_r.status       <= ST_DISPATCHED;
      res_r.out_proc_id  <= best_pid_r;
      res_r.out_estimate <= best_est_r;
      res_r.wait_ticks   <= best_w_r;
    end
    if (state_r == S_SCAN_CMP && cand_wins) begin
      best_w_r   <= cand_w_r;
      best_age_r <= cand_age_r;
      best_est_r <= cand_est_r;
      best_pid_r <= cand_pid_r;
      best_idx_r <= cand_idx_r;
    end
    // Load the next candidate from the read issued in the previous read state.
    if (state_r == S_DSP_LD0 || (state_r == S_SCAN_CMP && !cand_last)) begin
      cand_w_r   <= req_r.now_time - rd_entry.arrival;
      cand_age_r <= order_cnt_r - rd_entry.order;
      cand_est_r <= rd_entry.estimate;
      cand_pid_r <= rd_entry.pid;
      cand_idx_r <= (state_r == S_DSP_LD0) ? '0 : cand_idx_r + IDX_W'(1);
    end
    if (emit_load) begin
      out_r <= res_r;
    end
  end

endmodule

>>> dv/hrrn_sched_checker.sv
// Scoreboard for the ready-queue scheduler: watches the request, result and
// register channels, keeps its own copy of the process table, checks each result.
// Depends on hrrn_pkg.
module hrrn_sched_checker
  import hrrn_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_beat_t    in_beat,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_beat_t   out_beat,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_beat_t   cfg_beat,
  output int unsigned n_pending,
  output int unsigned n_fail
);

  logic             mode_q;
  logic [8:0]       alpha_q;
  logic [DEPTH-1:0] live;
  entry_t           slots [DEPTH];
  logic [31:0]      seq_cnt;
  out_beat_t        result_q [$];

  initial begin
    n_fail    = 0;
    n_pending = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_fail < 100) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    n_fail++;
  endtask

  function automatic logic [31:0] blend_estimate(logic [31:0] prior, logic [31:0] last,
                                                 logic refresh);
    logic [63:0] a;
    logic [63:0] v;
    a = (alpha_q > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_q);
    v = 64'(prior);
    if (refresh) begin
      v = (a * 64'(prior) + (64'(ALPHA_ONE) - a) * 64'(last)) >> 8;
    end
    if (v == 64'd0) begin
      v = 64'd1;
    end
    return v[31:0];
  endfunction

  // True when entry i should be dispatched ahead of entry j.
  function automatic logic outranks(int i, int j, logic [31:0] now);
    logic [31:0] age_i;
    logic [31:0] age_j;
    logic [31:0] wait_i;
    logic [31:0] wait_j;
    logic [63:0] lhs;
    logic [63:0] rhs;
    age_i = seq_cnt - slots[i].order;
    age_j = seq_cnt - slots[j].order;
    if (mode_q == MODE_HRRN) begin
      wait_i = now - slots[i].arrival;
      wait_j = now - slots[j].arrival;
      // compare wait_i/est_i against wait_j/est_j without division
      lhs = 64'(wait_i) * 64'(slots[j].estimate);
      rhs = 64'(wait_j) * 64'(slots[i].estimate);
      if (lhs != rhs) begin
        return lhs > rhs;
      end
    end
    return age_i > age_j;
  endfunction

  function automatic out_beat_t schedule_request(in_beat_t b);
    out_beat_t   r;
    int          pick;
    logic [31:0] est;
    pick = -1;
    r    = '0;
    if (b.op == OP_ENQUEUE) begin
      est = blend_estimate(b.prior_estimate, b.last_burst, b.refresh_estimate);
      for (int k = 0; k < DEPTH; k++) begin
        if (!live[k] && pick < 0) begin
          pick = k;
        end
      end
      r.out_proc_id  = b.proc_id;
      r.out_estimate = est;
      if (pick < 0) begin
        r.status = ST_FULL;
      end else begin
        live[pick]  = 1'b1;
        slots[pick] = '{pid: b.proc_id, arrival: b.now_time, estimate: est, order: seq_cnt};
        seq_cnt     = seq_cnt + 32'd1;
        r.status    = ST_ENQUEUED;
      end
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (live[k] && (pick < 0 || outranks(k, pick, b.now_time))) begin
          pick = k;
        end
      end
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        live[pick]     = 1'b0;
        r.status       = ST_DISPATCHED;
        r.out_proc_id  = slots[pick].pid;
        r.out_estimate = slots[pick].estimate;
        r.wait_ticks   = b.now_time - slots[pick].arrival;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      mode_q  = MODE_FIFO;
      alpha_q = ALPHA_RESET;
      live    = '0;
      seq_cnt = '0;
      result_q.delete();
    end else begin
      // retire the result before queueing a request taken on the same edge
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unrequested result, status", 32'(out_beat.status), 32'd0);
        end else begin
          want = result_q.pop_front();
          if (out_beat.status != want.status)
            report_mismatch("status", 32'(out_beat.status), 32'(want.status));
          if (out_beat.out_proc_id != want.out_proc_id)
            report_mismatch("out_proc_id", 32'(out_beat.out_proc_id), 32'(want.out_proc_id));
          if (out_beat.out_estimate != want.out_estimate)
            report_mismatch("out_estimate", out_beat.out_estimate, want.out_estimate);
          if (out_beat.wait_ticks != want.wait_ticks)
            report_mismatch("wait_ticks", out_beat.wait_ticks, want.wait_ticks);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_beat.reg_idx)
          REG_SCHED_MODE: mode_q = cfg_beat.wdata[0];
          REG_ALPHA_Q8:   alpha_q = cfg_beat.wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        result_q.push_back(schedule_request(in_beat));
      end
    end
    n_pending = result_q.size();
  end

endmodule

>>> dv/hrrn_ready_queue_scheduler_core_tb.sv
// Top of the scheduler testbench: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict.
// Depends on hrrn_pkg, hrrn_chan_if, hrrn_ready_queue_scheduler_core, hrrn_sched_checker.
module hrrn_ready_queue_scheduler_core_tb
  import hrrn_pkg::*;
();

  localparam int unsigned DEPTH         = 32;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned PHASE_ITEMS   = 185;
  localparam int unsigned N_PHASES      = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

  logic        clk;
  logic        rst_n;
  int unsigned n_pending;
  int unsigned n_fail;
  logic [31:0] tick_now;
  logic        in_calm;
  logic        out_calm;
  int unsigned out_hold;
  int unsigned quiet;

  logic       phase_mode  [N_PHASES] = '{MODE_HRRN, MODE_HRRN, MODE_FIFO, MODE_HRRN,
                                         MODE_FIFO, MODE_HRRN, MODE_FIFO, MODE_HRRN};
  logic [8:0] phase_alpha [N_PHASES] = '{9'd0, 9'd256, 9'd511, 9'd300,
                                         9'd77, 9'd0, 9'd256, 9'd128};

  hrrn_chan_if #(.payload_t(in_beat_t))  in_ch ();
  hrrn_chan_if #(.payload_t(out_beat_t)) out_ch ();
  hrrn_chan_if #(.payload_t(cfg_beat_t)) cfg_ch ();

  hrrn_ready_queue_scheduler_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  hrrn_sched_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_beat   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_ch.payload),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_beat  (cfg_ch.payload),
    .n_pending (n_pending),
    .n_fail    (n_fail)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly small estimates so ratios tie and cross often; some full range.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 64);
    if (r < 80) return $urandom_range(1, 5000);
    return $urandom();
  endfunction

  function automatic void advance_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) tick_now = $urandom();
    else if (r < 5) tick_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else tick_now = tick_now + $urandom_range(0, 24);
  endfunction

  function automatic in_beat_t make_enqueue();
    in_beat_t b;
    b.op               = OP_ENQUEUE;
    b.now_time         = tick_now;
    b.proc_id          = 16'($urandom());
    b.prior_estimate   = pick_value();
    b.last_burst       = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_value();
    b.refresh_estimate = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic in_beat_t make_dispatch();
    in_beat_t b;
    b.op               = OP_DISPATCH;
    // now and then a random time, which may lie before the arrivals, so the wait wraps
    b.now_time         = ($urandom_range(0, 19) == 0) ? $urandom() : tick_now;
    b.proc_id          = 16'($urandom());
    b.prior_estimate   = $urandom();
    b.last_burst       = $urandom();
    b.refresh_estimate = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Leaves valid high after the beat; the next call keeps it or lowers it for a gap, settle() lowers it.
  task automatic send_req(in_beat_t b);
    int unsigned gap;
    gap = (in_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic enq(logic [15:0] pid, logic [31:0] now, logic [31:0] prior,
                     logic [31:0] last, logic refresh);
    in_beat_t b;
    b = '{op: OP_ENQUEUE, now_time: now, proc_id: pid, prior_estimate: prior,
          last_burst: last, refresh_estimate: refresh};
    send_req(b);
  endtask

  task automatic disp(logic [31:0] now);
    in_beat_t b;
    b = '{op: OP_DISPATCH, now_time: now, proc_id: '0, prior_estimate: '0,
          last_burst: '0, refresh_estimate: 1'b0};
    send_req(b);
  endtask

  // Drop valid and hold until every result is back.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{reg_idx: idx, wdata: data};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_traffic(int unsigned n_items);
    int unsigned enq_pct;
    int unsigned left;
    enq_pct = 50;
    left    = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (left == 0) begin
        // bias toward enqueue or dispatch so the table fills and drains
        left = $urandom_range(20, 60);
        case ($urandom_range(0, 3))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          2:       enq_pct = 70;
          default: enq_pct = 95;
        endcase
        in_calm = ($urandom_range(0, 4) == 0);
      end
      left--;
      advance_time();
      if ($urandom_range(0, 99) < enq_pct) send_req(make_enqueue());
      else send_req(make_dispatch());
    end
  endtask

  // Result back-pressure.
  initial begin
    out_ch.ready = 1'b0;
    out_calm     = 1'b0;
    out_hold     = 0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [8:0] alpha;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    in_calm        = 1'b0;
    tick_now       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // FIFO with reset alpha: empty table, field extremes, zero estimates
    disp(32'd0);
    enq(16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    enq(16'h0000, 32'd10, 32'd0, 32'hFFFF_FFFF, 1'b0);
    enq(16'h1234, 32'd20, 32'd1, 32'd0, 1'b1);
    enq(16'h00FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    enq(16'hA5A5, 32'd30, 32'd0, 32'd1000, 1'b1);
    disp(32'd5);
    disp(32'd0);
    disp(32'hFFFF_FFFF);
    disp(32'd100);
    disp(32'd200);
    disp(32'd300);

    // HRRN, alpha one: ratio order, ties to the oldest, unused register index
    settle();
    write_reg(REG_SCHED_MODE, CFG_DATA_W'(MODE_HRRN));
    write_reg(REG_ALPHA_Q8, ALPHA_ONE);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    enq(16'd1, 32'd100, 32'd10, 32'd999, 1'b1);
    enq(16'd2, 32'd100, 32'd10, 32'd0, 1'b0);
    enq(16'd3, 32'd150, 32'd1, 32'd0, 1'b0);
    enq(16'd4, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    disp(32'd200);
    disp(32'd200);
    disp(32'd200);
    disp(32'd200);
    tick_now = 32'd1000;

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      alpha = (p == 5) ? 9'($urandom_range(0, 511)) : phase_alpha[p];
      write_reg(REG_SCHED_MODE, CFG_DATA_W'({$urandom(), phase_mode[p]}));
      write_reg(REG_ALPHA_Q8, alpha);
      run_traffic(PHASE_ITEMS);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> hrrn_ready_queue_scheduler_core.f
src/hrrn_pkg.sv
src/hrrn_chan_if.sv
src/hrrn_ram.sv
src/hrrn_mul2.sv
src/hrrn_ready_queue_scheduler_core.sv
dv/hrrn_sched_checker.sv
dv/hrrn_ready_queue_scheduler_core_tb.sv
